// File: sv/rprw_pkg.sv
// Shared types and constants for the reader-preference reader-writer lock.
`default_nettype none

package rprw_pkg;

  localparam int unsigned ID_BITS       = 8;
  localparam int unsigned READER_MAX    = 255;
  localparam int unsigned RECURSION_MAX = 255;

  // Effective limits and id mask, all capped to the 8-bit state fields.
  localparam logic [7:0] RD_LIM  = 8'((READER_MAX > 255) ? 255 : READER_MAX);
  localparam logic [7:0] DEP_LIM = 8'((RECURSION_MAX > 255) ? 255 : RECURSION_MAX);
  localparam logic [7:0] ID_MASK = (ID_BITS >= 8) ? 8'hFF : 8'((1 << ID_BITS) - 1);
  localparam logic [7:0] SOLO_ID = 8'd1;

  typedef enum logic [2:0] {
    ACT_READ    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_UPGRADE = 3'd3,
    ACT_RESET   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    MODE_UNLOCKED = 2'd0,
    MODE_READ     = 2'd1,
    MODE_WRITE    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_GRANT_READ  = 3'd0,
    ST_GRANT_WRITE = 3'd1,
    ST_BLOCKED     = 3'd2,
    ST_RELEASED    = 3'd3,
    ST_NOTHING     = 3'd4,
    ST_FULL        = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] held_mode;
    logic [7:0] requester_id;
    action_e    action;
  } req_t;

  typedef struct packed {
    logic       writer_now;
    logic [7:0] readers_now;
    logic       wake_waiters;
    mode_e      new_held_mode;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic [7:0] readers;
    logic       writer;
    logic       sleep;
    logic [7:0] owner;
    logic [7:0] depth;
  } lock_t;

endpackage

`default_nettype wire

// File: sv/rprw_lock.sv
// Lock state registers and the per-request decision logic.
`default_nettype none

module rprw_lock (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          step_i,
  input  wire rprw_pkg::req_t req_i,
  output rprw_pkg::res_t     res_o
);
  import rprw_pkg::*;

  typedef struct packed {
    lock_t   lk;
    status_e st;
    mode_e   md;
  } acq_t;

  typedef struct packed {
    lock_t   lk;
    status_e st;
    logic    wake;
  } rel_t;

  logic  threaded_q;
  lock_t lock_q, lock_d;
  logic [7:0] id;
  mode_e hm;
  acq_t  acq;
  rel_t  rel;

  function automatic acq_t f_reacquire(lock_t s);
    acq_t r;
    r.lk = s;
    r.md = MODE_WRITE;
    if (s.depth >= DEP_LIM) begin
      r.st = ST_FULL;
    end else begin
      r.lk.depth = s.depth + 8'd1;
      r.st = ST_GRANT_WRITE;
    end
    return r;
  endfunction

  function automatic acq_t f_read(lock_t s, logic [7:0] rid, mode_e m);
    acq_t r;
    r.lk = s;
    r.st = ST_BLOCKED;
    r.md = m;
    if (!s.writer) begin
      if (s.readers >= RD_LIM) begin
        r.st = ST_FULL;
      end else begin
        r.lk.readers = s.readers + 8'd1;
        r.st = ST_GRANT_READ;
        r.md = MODE_READ;
      end
    end else if (s.owner == rid) begin
      r = f_reacquire(s);
    end else begin
      r.lk.sleep = 1'b1;
    end
    return r;
  endfunction

  function automatic acq_t f_write(lock_t s, logic [7:0] rid, mode_e m);
    acq_t r;
    r.lk = s;
    r.st = ST_BLOCKED;
    r.md = m;
    if (s.writer && s.owner == rid) begin
      r = f_reacquire(s);
    end else if (!s.writer && s.readers == 8'd0) begin
      r.lk.writer = 1'b1;
      r.lk.owner  = rid;
      r.lk.depth  = 8'd1;
      r.st = ST_GRANT_WRITE;
      r.md = MODE_WRITE;
    end else begin
      r.lk.sleep = 1'b1;
    end
    return r;
  endfunction

  // The writer release does not check the owner id.
  function automatic rel_t f_release(lock_t s);
    rel_t r;
    r.lk   = s;
    r.st   = ST_RELEASED;
    r.wake = 1'b0;
    if (!s.writer) begin
      if (s.readers == 8'd0) begin
        r.st = ST_NOTHING;
      end else begin
        r.lk.readers = s.readers - 8'd1;
        if (s.readers == 8'd1 && s.sleep) begin
          r.lk.sleep = 1'b0;
          r.wake = 1'b1;
        end
      end
    end else begin
      if (s.depth != 8'd0) begin
        r.lk.depth = s.depth - 8'd1;
      end
      if (r.lk.depth == 8'd0) begin
        r.lk.writer = 1'b0;
        r.lk.owner  = 8'd0;
        if (s.readers == 8'd0 && s.sleep) begin
          r.lk.sleep = 1'b0;
          r.wake = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign id = threaded_q ? (req_i.requester_id & ID_MASK) : SOLO_ID;
  // Held mode three is taken as write.
  assign hm = req_i.held_mode[1] ? MODE_WRITE : mode_e'(req_i.held_mode);

  always_comb begin
    lock_d = lock_q;
    res_o.status = ST_NOTHING;
    res_o.new_held_mode = hm;
    res_o.wake_waiters = 1'b0;
    acq = '0;
    rel = '0;
    case (req_i.action)
      ACT_READ: begin
        acq = f_read(lock_q, id, hm);
        lock_d = acq.lk;
        res_o.status = acq.st;
        res_o.new_held_mode = acq.md;
      end
      ACT_WRITE: begin
        acq = f_write(lock_q, id, hm);
        lock_d = acq.lk;
        res_o.status = acq.st;
        res_o.new_held_mode = acq.md;
      end
      ACT_RELEASE: begin
        res_o.new_held_mode = MODE_UNLOCKED;
        if (hm != MODE_UNLOCKED) begin
          rel = f_release(lock_q);
          lock_d = rel.lk;
          res_o.status = rel.st;
          res_o.wake_waiters = rel.wake;
        end
      end
      ACT_UPGRADE: begin
        if (hm == MODE_UNLOCKED) begin
          res_o.new_held_mode = MODE_UNLOCKED;
        end else if (hm == MODE_WRITE) begin
          res_o.status = ST_GRANT_WRITE;
          res_o.new_held_mode = MODE_WRITE;
        end else begin
          // Give up the read hold, then try for the write lock.
          rel = f_release(lock_q);
          acq = f_write(rel.lk, id, MODE_UNLOCKED);
          lock_d = acq.lk;
          res_o.status = acq.st;
          res_o.new_held_mode = acq.md;
          res_o.wake_waiters = rel.wake;
        end
      end
      ACT_RESET: begin
        lock_d = '0;
        res_o.status = ST_RELEASED;
        res_o.new_held_mode = MODE_UNLOCKED;
      end
      default: begin
        res_o.status = ST_NOTHING;
        res_o.new_held_mode = hm;
      end
    endcase
    res_o.readers_now = lock_d.readers;
    res_o.writer_now  = lock_d.writer;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threaded_q <= 1'b0;
      lock_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        threaded_q <= cfg_wdata_i;
      end
      if (step_i) begin
        lock_q <= lock_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/reader_pref_rw_lock_core.sv
// Top level of the reader-preference reader-writer lock with stream ports.
//
// Requests arrive on the s_axis channel, one transaction per request, and
// each produces exactly one result transaction on the m_axis channel.
// A request is captured in an input register; once the output register is
// free or draining, the decision is made against the current lock state,
// the state is updated, and the result is loaded into the output register.
// One request per cycle is sustained while m_axis_tready stays high, the
// decision being combinational between the input and output registers.
// When the receiver holds m_axis_tready low, the result stays in the output
// register, one further request waits in the input register, and then
// s_axis_tready drops until the output register drains.
// The threaded bit is written through cfg_we_i/cfg_wdata_i; the user must do
// so only while no request is in flight, which the block does not enforce.
// Reset clears the lock state, the threaded bit and both pipeline valid
// flags; no request is lost or repeated across stalls.
`default_nettype none

module reader_pref_rw_lock_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] action, [10:3] requester_id, [12:11] held_mode, [15:13] zero
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] status, [4:3] new_held_mode, [5] wake_waiters, [13:6] readers_now,
  // [14] writer_now, [15] zero
  output logic [15:0]      m_axis_tdata
);
  import rprw_pkg::*;

  logic in_valid_q;
  req_t in_req_q;
  logic out_valid_q, out_valid_d;
  res_t out_q, res;
  logic advance;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  rprw_lock u_lock (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .req_i       (in_req_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q.action       <= action_e'(s_axis_tdata[2:0]);
      in_req_q.requester_id <= s_axis_tdata[10:3];
      in_req_q.held_mode    <= s_axis_tdata[12:11];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.writer_now, out_q.readers_now, out_q.wake_waiters,
                          out_q.new_held_mode, out_q.status};

`ifndef NO_ASSERTIONS
  // A decided request always shows up as a result in the next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("decided request did not reach the output register");

  // A writer and active readers never coexist.
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.writer_now && out_q.readers_now != 8'd0))
    else $error("writer held while readers are counted");

  // A wake only comes from a release, possibly inside an upgrade, which then
  // either gets the write lock or is refused.
  a_wake_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.wake_waiters) |->
      (out_q.status == ST_RELEASED || out_q.status == ST_BLOCKED ||
       out_q.status == ST_GRANT_WRITE))
    else $error("wake raised without a release");

  // A write grant always leaves the requester in write mode.
  a_grant_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status == ST_GRANT_WRITE) |->
      (out_q.new_held_mode == MODE_WRITE))
    else $error("write grant without write mode");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the reader-preference reader-writer lock core.
module tb_top;
  import rprw_pkg::*;

  localparam int RD_CAP        = (READER_MAX > 255) ? 255 : READER_MAX;
  localparam int DEP_CAP       = (RECURSION_MAX > 255) ? 255 : RECURSION_MAX;
  localparam logic [7:0] ID_KEEP = (ID_BITS >= 8) ? 8'hFF : 8'((1 << ID_BITS) - 1);
  localparam logic [7:0] SINGLE_ID = 8'd1;
  localparam logic [2:0] ACT_BAD_LO = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD_HI = 3'd7;
  localparam logic [1:0] HELD_ODD = 2'd3;
  localparam int PHASE_ITEMS   = 580;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 5_000_000;

  typedef enum int {BURST_NONE, BURST_READERS, BURST_DEPTH} burst_e;

  typedef struct {
    logic       thr;
    logic [2:0] act;
    logic [7:0] id;
    logic [1:0] hm;
    logic       typed;
    res_t       want;
  } row_t;

  typedef struct {
    logic typed;
    res_t want;
  } pend_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Lock state and threading bit as this bench believes them to be.
  logic [7:0] lk_readers = '0;
  logic       lk_writer = 1'b0;
  logic       lk_sleep = 1'b0;
  logic [7:0] lk_owner = '0;
  logic [7:0] lk_depth = '0;
  logic       lk_threaded = 1'b0;

  mode_e held_tab [0:255];
  row_t  dir_tab [$];
  pend_t req_q [$];
  res_t  answer_q [$];

  int sent_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int n_block = 0;
  int n_wake = 0;
  int n_full = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  reader_pref_rw_lock_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  // Write acquire: recursion for the owner, a fresh grant on a free lock,
  // otherwise the requester is refused and sleep-pending is set.
  function automatic status_e grab_write(input logic [7:0] id, input mode_e hm,
                                         output mode_e nm);
    if (lk_writer && lk_owner == id) begin
      nm = MODE_WRITE;
      if (lk_depth >= DEP_CAP) return ST_FULL;
      lk_depth++;
      return ST_GRANT_WRITE;
    end
    if (!lk_writer && lk_readers == 0) begin
      lk_writer = 1'b1;
      lk_owner = id;
      lk_depth = 8'd1;
      nm = MODE_WRITE;
      return ST_GRANT_WRITE;
    end
    lk_sleep = 1'b1;
    nm = hm;
    return ST_BLOCKED;
  endfunction

  function automatic status_e drop_hold(output logic wake);
    wake = 1'b0;
    if (!lk_writer) begin
      if (lk_readers == 0) return ST_NOTHING;
      lk_readers--;
    end else begin
      // No owner check here: any writer-mode release unwinds one level.
      if (lk_depth > 0) lk_depth--;
      if (lk_depth != 0) return ST_RELEASED;
      lk_writer = 1'b0;
      lk_owner = '0;
    end
    if (lk_readers == 0 && lk_sleep) begin
      lk_sleep = 1'b0;
      wake = 1'b1;
    end
    return ST_RELEASED;
  endfunction

  function automatic res_t lock_decide(input logic [15:0] word);
    logic [2:0] act;
    logic [7:0] id;
    mode_e      hm;
    mode_e      nm;
    status_e    st;
    logic       wk;
    res_t       r;
    act = word[2:0];
    id = lk_threaded ? (word[10:3] & ID_KEEP) : SINGLE_ID;
    hm = (word[12:11] == HELD_ODD) ? MODE_WRITE : mode_e'(word[12:11]);
    nm = MODE_UNLOCKED;
    wk = 1'b0;
    case (act)
      ACT_READ: begin
        if (!lk_writer) begin
          if (lk_readers >= RD_CAP) begin
            st = ST_FULL;
            nm = hm;
          end else begin
            lk_readers++;
            st = ST_GRANT_READ;
            nm = MODE_READ;
          end
        end else if (lk_owner == id) begin
          nm = MODE_WRITE;
          if (lk_depth >= DEP_CAP) begin
            st = ST_FULL;
          end else begin
            lk_depth++;
            st = ST_GRANT_WRITE;
          end
        end else begin
          lk_sleep = 1'b1;
          nm = hm;
          st = ST_BLOCKED;
        end
      end
      ACT_WRITE: st = grab_write(id, hm, nm);
      ACT_RELEASE: begin
        if (hm == MODE_UNLOCKED) st = ST_NOTHING;
        else st = drop_hold(wk);
      end
      ACT_UPGRADE: begin
        if (hm == MODE_UNLOCKED) begin
          st = ST_NOTHING;
        end else if (hm == MODE_WRITE) begin
          st = ST_GRANT_WRITE;
          nm = MODE_WRITE;
        end else begin
          // The read is given up first; a refused write leaves nothing held.
          void'(drop_hold(wk));
          st = grab_write(id, MODE_UNLOCKED, nm);
        end
      end
      ACT_RESET: begin
        lk_readers = '0;
        lk_writer = 1'b0;
        lk_sleep = 1'b0;
        lk_owner = '0;
        lk_depth = '0;
        st = ST_RELEASED;
      end
      default: begin
        st = ST_NOTHING;
        nm = hm;
      end
    endcase
    r = '0;
    r.status = st;
    r.new_held_mode = nm;
    r.wake_waiters = wk;
    r.readers_now = lk_readers;
    r.writer_now = lk_writer;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Receiver side: random backpressure at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Requests are scored when accepted, results compared when they leave.
  always @(posedge clk_i) begin
    pend_t tag;
    res_t  guess;
    res_t  want;
    res_t  got;
    if (rst_ni) begin
      if (cfg_we_i) lk_threaded = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        tag = req_q.pop_front();
        guess = lock_decide(s_axis_tdata);
        if (s_axis_tdata[2:0] == ACT_RESET) begin
          foreach (held_tab[i]) held_tab[i] = MODE_UNLOCKED;
        end else begin
          held_tab[s_axis_tdata[10:3]] = guess.new_held_mode;
        end
        want = tag.typed ? tag.want : guess;
        if (want.status == ST_BLOCKED) n_block++;
        if (want.status == ST_FULL) n_full++;
        if (want.wake_waiters) n_wake++;
        answer_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_cnt++;
        got = res_t'(m_axis_tdata[14:0]);
        if (answer_q.size() == 0) begin
          $error("result transaction with no request outstanding: %h", m_axis_tdata);
          err_cnt++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", 8'(want.status), 8'(got.status));
          check_field("new_held_mode", 8'(want.new_held_mode), 8'(got.new_held_mode));
          check_field("wake_waiters", 8'(want.wake_waiters), 8'(got.wake_waiters));
          check_field("readers_now", want.readers_now, got.readers_now);
          check_field("writer_now", 8'(want.writer_now), 8'(got.writer_now));
        end
      end
    end
  end

  task automatic issue(input logic [2:0] act, input logic [7:0] id, input logic [1:0] hm,
                       input logic typed, input res_t want);
    pend_t tag;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    tag.typed = typed;
    tag.want = want;
    req_q.push_back(tag);
    sent_cnt++;
    s_axis_tdata <= {3'b000, hm, id, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (got_cnt != sent_cnt) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threaded(input logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void row_want(input int thr, input logic [2:0] act,
                                   input logic [7:0] id, input logic [1:0] hm,
                                   input status_e st, input mode_e nm, input int wk,
                                   input int rd, input int wr);
    row_t r;
    r.thr = 1'(thr);
    r.act = act;
    r.id = id;
    r.hm = hm;
    r.typed = 1'b1;
    r.want = '0;
    r.want.status = st;
    r.want.new_held_mode = nm;
    r.want.wake_waiters = 1'(wk);
    r.want.readers_now = 8'(rd);
    r.want.writer_now = 1'(wr);
    dir_tab.push_back(r);
  endfunction

  function automatic void row_pred(input int thr, input logic [2:0] act,
                                   input logic [7:0] id, input logic [1:0] hm);
    row_t r;
    r.thr = 1'(thr);
    r.act = act;
    r.id = id;
    r.hm = hm;
    r.typed = 1'b0;
    r.want = '0;
    dir_tab.push_back(r);
  endfunction

  // Drive either the reader count or the owner's recursion to its cap and one past.
  task automatic fill_to_limit(input logic deep);
    logic [7:0] owner;
    owner = 8'($urandom);
    issue(ACT_RESET, owner, MODE_UNLOCKED, 1'b0, '0);
    if (!deep) begin
      repeat (RD_CAP + 1) issue(ACT_READ, 8'($urandom), MODE_UNLOCKED, 1'b0, '0);
      issue(ACT_RELEASE, owner, MODE_READ, 1'b0, '0);
    end else begin
      issue(ACT_WRITE, owner, MODE_UNLOCKED, 1'b0, '0);
      repeat (DEP_CAP) begin
        issue($urandom_range(1) ? ACT_READ : ACT_WRITE, owner, MODE_WRITE, 1'b0, '0);
      end
      issue(ACT_RELEASE, owner, MODE_WRITE, 1'b0, '0);
    end
    issue(ACT_RESET, owner, MODE_UNLOCKED, 1'b0, '0);
  endtask

  task automatic run_phase(input logic thr, input int src_pct, input int sink_pct,
                           input burst_e burst);
    int         start;
    int         roll;
    bit         paused;
    logic [7:0] id;
    logic [2:0] act;
    logic [1:0] hm;
    settle();
    set_threaded(thr);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    start = sent_cnt;
    paused = 1'b0;
    if (burst != BURST_NONE) fill_to_limit(burst == BURST_DEPTH);
    while (sent_cnt - start < PHASE_ITEMS) begin
      if (!paused && sent_cnt - start >= PHASE_ITEMS / 2) begin
        settle();
        paused = 1'b1;
      end
      id = ($urandom_range(99) < 80) ? 8'($urandom_range(4, 1)) : 8'($urandom);
      hm = held_tab[id];
      roll = $urandom_range(99);
      if (roll < 12) begin
        act = 3'($urandom_range(ACT_BAD_HI, 0));
        hm = 2'($urandom_range(HELD_ODD, 0));
        id = 8'($urandom);
      end else if (hm == MODE_UNLOCKED) begin
        act = (roll < 60) ? ACT_READ : (roll < 97) ? ACT_WRITE : ACT_RESET;
      end else begin
        act = (roll < 60) ? ACT_RELEASE : (roll < 78) ? ACT_UPGRADE :
              (roll < 89) ? ACT_READ : ACT_WRITE;
      end
      issue(act, id, hm, 1'b0, '0);
    end
  endtask

  initial begin
    logic cur_thr;
    int   n_dir;
    foreach (held_tab[i]) held_tab[i] = MODE_UNLOCKED;

    // Single-threaded: every requester counts as the same id.
    row_want(0, ACT_RELEASE, 8'h00, MODE_UNLOCKED, ST_NOTHING, MODE_UNLOCKED, 0, 0, 0);
    row_want(0, ACT_RELEASE, 8'hFF, MODE_READ, ST_NOTHING, MODE_UNLOCKED, 0, 0, 0);
    row_want(0, ACT_UPGRADE, 8'h00, MODE_UNLOCKED, ST_NOTHING, MODE_UNLOCKED, 0, 0, 0);
    row_want(0, ACT_READ, 8'h00, MODE_UNLOCKED, ST_GRANT_READ, MODE_READ, 0, 1, 0);
    row_want(0, ACT_WRITE, 8'hAA, MODE_UNLOCKED, ST_BLOCKED, MODE_UNLOCKED, 0, 1, 0);
    row_want(0, ACT_RELEASE, 8'h55, MODE_READ, ST_RELEASED, MODE_UNLOCKED, 1, 0, 0);
    row_want(0, ACT_WRITE, 8'h00, MODE_UNLOCKED, ST_GRANT_WRITE, MODE_WRITE, 0, 0, 1);
    row_pred(0, ACT_READ, 8'hFF, MODE_UNLOCKED);
    row_want(0, ACT_UPGRADE, 8'h12, MODE_WRITE, ST_GRANT_WRITE, MODE_WRITE, 0, 0, 1);
    row_want(0, ACT_UPGRADE, 8'h34, HELD_ODD, ST_GRANT_WRITE, MODE_WRITE, 0, 0, 1);
    row_want(0, ACT_BAD_LO, 8'h00, HELD_ODD, ST_NOTHING, MODE_WRITE, 0, 0, 1);
    row_want(0, ACT_BAD_HI, 8'hFF, MODE_READ, ST_NOTHING, MODE_READ, 0, 0, 1);
    row_pred(0, ACT_RELEASE, 8'h00, MODE_WRITE);
    row_want(0, ACT_RELEASE, 8'h00, HELD_ODD, ST_RELEASED, MODE_UNLOCKED, 0, 0, 0);
    row_want(0, ACT_RESET, 8'hFF, HELD_ODD, ST_RELEASED, MODE_UNLOCKED, 0, 0, 0);
    // Threaded: ids are distinct, ownership matters.
    row_want(1, ACT_READ, 8'hFF, MODE_UNLOCKED, ST_GRANT_READ, MODE_READ, 0, 1, 0);
    row_pred(1, ACT_UPGRADE, 8'hFF, MODE_READ);
    row_want(1, ACT_READ, 8'h00, MODE_UNLOCKED, ST_BLOCKED, MODE_UNLOCKED, 0, 0, 1);
    row_want(1, ACT_WRITE, 8'h01, MODE_READ, ST_BLOCKED, MODE_READ, 0, 0, 1);
    row_pred(1, ACT_WRITE, 8'hFF, MODE_WRITE);
    row_pred(1, ACT_RELEASE, 8'h80, MODE_WRITE);
    row_want(1, ACT_RELEASE, 8'h01, MODE_WRITE, ST_RELEASED, MODE_UNLOCKED, 1, 0, 0);
    row_pred(1, ACT_READ, 8'h01, MODE_UNLOCKED);
    row_pred(1, ACT_READ, 8'h02, MODE_UNLOCKED);
    row_want(1, ACT_UPGRADE, 8'h01, MODE_READ, ST_BLOCKED, MODE_UNLOCKED, 0, 1, 0);
    row_pred(1, ACT_UPGRADE, 8'h02, MODE_READ);
    row_want(1, ACT_BAD_MID, 8'h7F, MODE_UNLOCKED, ST_NOTHING, MODE_UNLOCKED, 0, 0, 1);
    row_want(1, ACT_RESET, 8'h00, MODE_UNLOCKED, ST_RELEASED, MODE_UNLOCKED, 0, 0, 0);
    n_dir = dir_tab.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 15;
    sink_idle_pct = 77;
    set_threaded(1'b0);
    cur_thr = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].thr != cur_thr) begin
        settle();
        set_threaded(dir_tab[i].thr);
        cur_thr = dir_tab[i].thr;
      end
      issue(dir_tab[i].act, dir_tab[i].id, dir_tab[i].hm, dir_tab[i].typed,
            dir_tab[i].want);
    end

    run_phase(1'b0, 15, 77, BURST_READERS);
    run_phase(1'b1, 77, 15, BURST_DEPTH);
    run_phase(1'b1, 0, 0, BURST_NONE);
    settle();

    if (answer_q.size() != 0) begin
      $error("%0d expected results never arrived", answer_q.size());
      err_cnt++;
    end
    $display("Ran %0d lock requests (%0d directed) in both threading modes under varied stalls.",
             sent_cnt, n_dir);
    $display("Expected %0d blocked, %0d wake-ups and %0d count-full answers.",
             n_block, n_wake, n_full);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rprw_pkg.sv
sv/rprw_lock.sv
sv/reader_pref_rw_lock_core.sv
verif/tb_top.sv
